[rtl/ibhq_pkg.sv]
// shared constants, types and helpers for the indexed binary heap queue
package ibhq_pkg;

  localparam int CAPACITY   = 256;
  localparam int KEY_W      = 32;
  localparam int TAG_W      = 8;
  localparam int TAG_COUNT  = 1 << TAG_W;
  localparam int POS_W      = $clog2(CAPACITY + 1);
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int OP_W       = 3;
  localparam int ST_W       = 3;
  localparam int IO_KEY_W   = 32;
  localparam int CNT_W      = 9;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_TOP    = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_NEXT   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd2;
  localparam logic [ST_W-1:0] ST_ABSENT = 3'd3;
  localparam logic [ST_W-1:0] ST_HELD   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             from_start;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]     status;
    logic [IO_KEY_W-1:0] key;
    logic [TAG_W-1:0]    tag;
    logic [CNT_W-1:0]    count;
  } rsp_t;

  function automatic logic ranks_above(input logic mode, input logic [KEY_W-1:0] a,
                                       input logic [KEY_W-1:0] b);
    return mode ? (a <= b) : (a >= b);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] d;
    d = p - POS_W'(1);
    return d[ADDR_W-1:0];
  endfunction

endpackage

[rtl/indexed_binary_heap_queue_top.sv]
// indexed binary heap queue: stream ports, order mode register, result register
// sequence: a rejected request goes straight to the result; top reads the root slot; next reads
// the tag's position, then the slot after it (empty past the end); insert climbs level by level;
// pop and delete fill the hole with the last entry and sift it down (delete may sift it up)
// throughput: one request at a time, set by the slot memory (one read per cycle, registered
// data) and the one shared key comparator; the next request is taken while a result waits
// reset: synchronous active-low, clears control, mode, count and tag valid bits
module indexed_binary_heap_queue_top
  import ibhq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // key[31:0], tag[39:32], from_start[40], zero pad
  input  logic [OP_W-1:0]       in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_key[31:0], out_tag[39:32], entry_count[48:40]
  output logic [ST_W-1:0]       out_tuser,  // status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data
);

  logic mode_r;
  logic out_valid_r;
  rsp_t out_rsp_r;
  req_t req;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_ready;

  assign req.op         = in_tuser;
  assign req.key        = KEY_W'(in_tdata[IO_KEY_W-1:0]);
  assign req.tag        = in_tdata[IO_KEY_W+TAG_W-1:IO_KEY_W];
  assign req.from_start = in_tdata[IO_KEY_W+TAG_W];

  assign cfg_ready = 1'b1;
  assign rsp_ready = !out_valid_r || out_tready;

  ibhq_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .order_mode (mode_r),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode_r <= cfg_data;
      end
      if (rsp_ready) begin
        out_valid_r <= rsp_valid;
      end
      if (rsp_valid && rsp_ready) begin
        out_rsp_r <= rsp;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_rsp_r.status;
  assign out_tdata  = OUT_DATA_W'({out_rsp_r.count, out_rsp_r.tag, out_rsp_r.key});

endmodule

[rtl/ibhq_core.sv]
// heap sequencer with slot memory, tag position memory and shared key compare
module ibhq_core
  import ibhq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic order_mode,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  typedef enum logic [3:0] {
    S_IDLE, S_TPOS, S_FETCH, S_RM_LAST, S_RM_PAR, S_UP_RD, S_UP_CMP,
    S_DN_L, S_DN_R, S_DN_CMPR, S_DN_CMP, S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [TAG_W-1:0]     tag_r, tag_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [POS_W-1:0]     cnt_r, cnt_nxt;
  logic [KEY_W-1:0]     ck_r, ck_nxt;
  logic [TAG_W-1:0]     ct_r, ct_nxt;
  logic [POS_W-1:0]     cpos_r, cpos_nxt;
  logic [ST_W-1:0]      status_r, status_nxt;
  logic [KEY_W-1:0]     okey_r, okey_nxt;
  logic [TAG_W-1:0]     otag_r, otag_nxt;
  logic [TAG_COUNT-1:0] valid_r;

  logic [TAG_W+KEY_W-1:0] slot_mem [CAPACITY];
  logic [TAG_W+KEY_W-1:0] slot_rd_r;
  logic [POS_W-1:0]       tpos_mem [TAG_COUNT];
  logic [POS_W-1:0]       tpos_rd_r;

  logic                   slot_we;
  logic [ADDR_W-1:0]      slot_waddr, slot_raddr;
  logic [TAG_W+KEY_W-1:0] slot_wdata;
  logic                   tp_we;
  logic [TAG_W-1:0]       tp_waddr, tp_raddr;
  logic [POS_W-1:0]       tp_wdata;
  logic                   vclr;
  logic [TAG_W-1:0]       vclr_tag;

  logic [KEY_W-1:0] rd_key;
  logic [TAG_W-1:0] rd_tag;
  logic [KEY_W-1:0] cmp_a, cmp_b;
  logic             cmp_hit;
  logic [POS_W:0]   left_pos, right_pos, cnt_ext;
  logic [OP_W-1:0]  op_eff;

  assign rd_key    = slot_rd_r[KEY_W-1:0];
  assign rd_tag    = slot_rd_r[TAG_W+KEY_W-1:KEY_W];
  assign left_pos  = {pos_r, 1'b0};
  assign right_pos = left_pos + (POS_W+1)'(1);
  assign cnt_ext   = {1'b0, cnt_r};
  assign cmp_hit   = ranks_above(order_mode, cmp_a, cmp_b);

  // shared compare operand select
  always_comb begin
    cmp_a = key_r;
    cmp_b = rd_key;
    unique case (state_r)
      S_RM_PAR, S_UP_CMP: begin
        cmp_a = rd_key;
        cmp_b = key_r;
      end
      S_DN_CMPR: begin
        cmp_a = rd_key;
        cmp_b = ck_r;
      end
      S_DN_CMP: begin
        cmp_a = key_r;
        cmp_b = ck_r;
      end
      default: begin
        cmp_a = key_r;
        cmp_b = rd_key;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    tag_nxt    = tag_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    ck_nxt     = ck_r;
    ct_nxt     = ct_r;
    cpos_nxt   = cpos_r;
    status_nxt = status_r;
    okey_nxt   = okey_r;
    otag_nxt   = otag_r;
    slot_we    = 1'b0;
    slot_waddr = slot_addr(pos_r);
    slot_wdata = {tag_r, key_r};
    slot_raddr = slot_addr(pos_r);
    tp_we      = 1'b0;
    tp_waddr   = tag_r;
    tp_wdata   = pos_r;
    tp_raddr   = req.tag;
    vclr       = 1'b0;
    vclr_tag   = rd_tag;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    op_eff     = (req.op == OP_NEXT && req.from_start) ? OP_TOP : req.op;
    unique case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op_nxt     = op_eff;
          key_nxt    = req.key;
          tag_nxt    = req.tag;
          status_nxt = ST_OK;
          okey_nxt   = '0;
          otag_nxt   = '0;
          state_nxt  = S_DONE;
          unique case (op_eff)
            OP_INSERT: begin
              if (valid_r[req.tag]) begin
                status_nxt = ST_HELD;
              end else if (cnt_r == POS_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                cnt_nxt   = cnt_r + POS_W'(1);
                pos_nxt   = cnt_r + POS_W'(1);
                state_nxt = S_UP_RD;
              end
            end
            OP_POP, OP_TOP: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                pos_nxt    = POS_W'(1);
                slot_raddr = '0;
                state_nxt  = S_FETCH;
              end
            end
            OP_DELETE, OP_NEXT: begin
              if (!valid_r[req.tag]) begin
                status_nxt = ST_ABSENT;
              end else begin
                state_nxt = S_TPOS;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_TPOS: begin
        if (tpos_rd_r == '0 || tpos_rd_r > cnt_r) begin
          status_nxt = ST_ABSENT;
          state_nxt  = S_DONE;
        end else if (op_r == OP_NEXT) begin
          if (tpos_rd_r >= cnt_r) begin
            status_nxt = ST_EMPTY;
            state_nxt  = S_DONE;
          end else begin
            slot_raddr = slot_addr(tpos_rd_r + POS_W'(1));
            state_nxt  = S_FETCH;
          end
        end else begin
          pos_nxt    = tpos_rd_r;
          slot_raddr = slot_addr(tpos_rd_r);
          state_nxt  = S_FETCH;
        end
      end
      S_FETCH: begin
        okey_nxt = rd_key;
        otag_nxt = rd_tag;
        if (op_r == OP_TOP || op_r == OP_NEXT) begin
          state_nxt = S_DONE;
        end else begin
          // remove the entry at pos, last entry fills the hole
          vclr     = 1'b1;
          vclr_tag = rd_tag;
          cnt_nxt  = cnt_r - POS_W'(1);
          if (pos_r == cnt_r) begin
            state_nxt = S_DONE;
          end else begin
            slot_raddr = slot_addr(cnt_r);
            state_nxt  = S_RM_LAST;
          end
        end
      end
      S_RM_LAST: begin
        key_nxt    = rd_key;
        tag_nxt    = rd_tag;
        slot_we    = 1'b1;
        slot_wdata = {rd_tag, rd_key};
        tp_we      = 1'b1;
        tp_waddr   = rd_tag;
        if (pos_r == POS_W'(1)) begin
          state_nxt = S_DN_L;
        end else begin
          slot_raddr = slot_addr(pos_r >> 1);
          state_nxt  = S_RM_PAR;
        end
      end
      S_RM_PAR, S_UP_CMP: begin
        if (cmp_hit) begin
          if (state_r == S_RM_PAR) begin
            state_nxt = S_DN_L;
          end else begin
            slot_we   = 1'b1;
            tp_we     = 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          slot_we    = 1'b1;
          slot_wdata = {rd_tag, rd_key};
          tp_we      = 1'b1;
          tp_waddr   = rd_tag;
          pos_nxt    = pos_r >> 1;
          state_nxt  = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (pos_r == POS_W'(1)) begin
          slot_we   = 1'b1;
          tp_we     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          slot_raddr = slot_addr(pos_r >> 1);
          state_nxt  = S_UP_CMP;
        end
      end
      S_DN_L: begin
        if (left_pos > cnt_ext) begin
          slot_we   = 1'b1;
          tp_we     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          slot_raddr = slot_addr(left_pos[POS_W-1:0]);
          state_nxt  = S_DN_R;
        end
      end
      S_DN_R: begin
        ck_nxt   = rd_key;
        ct_nxt   = rd_tag;
        cpos_nxt = left_pos[POS_W-1:0];
        if (right_pos <= cnt_ext) begin
          slot_raddr = slot_addr(right_pos[POS_W-1:0]);
          state_nxt  = S_DN_CMPR;
        end else if (cmp_hit) begin
          slot_we   = 1'b1;
          tp_we     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          slot_we    = 1'b1;
          slot_wdata = {rd_tag, rd_key};
          tp_we      = 1'b1;
          tp_waddr   = rd_tag;
          pos_nxt    = left_pos[POS_W-1:0];
          state_nxt  = S_DN_L;
        end
      end
      S_DN_CMPR: begin
        if (cmp_hit) begin
          ck_nxt   = rd_key;
          ct_nxt   = rd_tag;
          cpos_nxt = cpos_r + POS_W'(1);
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        slot_we = 1'b1;
        tp_we   = 1'b1;
        if (cmp_hit) begin
          state_nxt = S_DONE;
        end else begin
          slot_wdata = {ct_r, ck_r};
          tp_waddr   = ct_r;
          pos_nxt    = cpos_r;
          state_nxt  = S_DN_L;
        end
      end
      S_DONE: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      valid_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      op_r     <= op_nxt;
      key_r    <= key_nxt;
      tag_r    <= tag_nxt;
      pos_r    <= pos_nxt;
      ck_r     <= ck_nxt;
      ct_r     <= ct_nxt;
      cpos_r   <= cpos_nxt;
      status_r <= status_nxt;
      okey_r   <= okey_nxt;
      otag_r   <= otag_nxt;
      if (vclr) begin
        valid_r[vclr_tag] <= 1'b0;
      end
      if (tp_we) begin
        valid_r[tp_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rd_r <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (tp_we) begin
      tpos_mem[tp_waddr] <= tp_wdata;
    end
    tpos_rd_r <= tpos_mem[tp_raddr];
  end

  assign rsp.status = status_r;
  assign rsp.key    = IO_KEY_W'(okey_r);
  assign rsp.tag    = otag_r;
  assign rsp.count  = CNT_W'(cnt_r);

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= POS_W'(CAPACITY))
    else $error("entry count above capacity");

  a_valid_matches_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> $countones(valid_r) == int'(cnt_r))
    else $error("held tag count differs from entry count");

  a_up_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UP_RD |-> (pos_r != '0 && pos_r <= cnt_r))
    else $error("sift up position out of range");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_valid && status_r == ST_FULL) |-> cnt_r == POS_W'(CAPACITY))
    else $error("full reported below capacity");

endmodule
